@@ hdl/sve_pkg.sv @@
// sve_pkg: shared constants, sequencer states and status types for the
// sample variance engine; no dependencies, compiled first
package sve_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_BITS = 15;
  localparam int HEIGHT_BITS = 21;
  localparam int VAR_BITS    = 32;

  localparam int ADDR_W    = $clog2(MAX_SAMPLES);
  localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W     = SAMPLE_BITS + CNT_W;
  localparam int FRAC_BITS = 8;
  localparam int Q_SHIFT   = 2 * FRAC_BITS;
  localparam int MNUM_W    = SUM_W + FRAC_BITS + 1;
  localparam int MEAN_W    = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int DEV_W     = MEAN_W + 1;

  localparam int MUL_W     = 32;
  localparam int ACC_W     = 2 * MUL_W;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // 0.98^2 = 2401/2500
  localparam int SCALE_NUM = 2401;
  localparam int SCALE_DEN = 2500;
  localparam int SCALE_W   = $clog2(SCALE_DEN);
  localparam int DVS_W     = CNT_W + SCALE_W;

  typedef enum logic [3:0] {
    S_LOAD,
    S_DEN,
    S_MDIV_GO,
    S_MDIV_WAIT,
    S_PASS,
    S_SC_LO,
    S_SC_HI,
    S_SC_SUM,
    S_FDIV_GO,
    S_FDIV_WAIT,
    S_EMIT
  } sve_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/sve_if.sv @@
// sve_if: valid/ready channel interfaces for input samples and results
// depends on sve_pkg for field widths
interface sve_in_if import sve_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_sample;
  logic                          has_height;
  logic signed [HEIGHT_BITS-1:0] height_cm;
  logic                          last;

  modport source (output valid, output accel_sample, output has_height,
                  output height_cm, output last, input ready);
  modport sink   (input valid, input accel_sample, input has_height,
                  input height_cm, input last, output ready);
endinterface

interface sve_out_if import sve_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] initial_height;
  logic        [VAR_BITS-1:0]    accel_variance;
  logic                          too_few;

  modport source (output valid, output initial_height, output accel_variance,
                  output too_few, input ready);
  modport sink   (input valid, input initial_height, input accel_variance,
                  input too_few, output ready);
endinterface

@@ hdl/sve_ram.sv @@
// sve_ram: generic single-write, single-read RAM with registered read data
// no package dependency
module sve_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ hdl/sve_mul.sv @@
// sve_mul: shared unsigned multiplier with registered product
// depends on sve_pkg for MUL_W
module sve_mul import sve_pkg::*; (
  input  logic               clk,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic [2*MUL_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

@@ hdl/sve_div.sv @@
// sve_div: restoring divider, one quotient bit per cycle
// depends on sve_pkg for widths and div_stat_t
module sve_div import sve_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DVS_W-1:0]     den,
  output div_stat_t            stat,
  output logic [DIV_NUM_W-1:0] quo,
  output logic [DVS_W-1:0]     rem
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

  logic [DIV_NUM_W-1:0] quo_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [DVS_W-1:0] rem_step;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    rem_step = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
      rem_r <= rem_step;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;
  assign rem       = rem_r;

endmodule

@@ hdl/sample_variance_engine_core.sv @@
// sample_variance_engine_core: two-pass sample variance with latched start height
// depends on sve_pkg, sve_if, sve_ram, sve_mul and sve_div
//
// usage
//   in_if carries one acceleration sample per transaction, optionally with a
//   barometric height; the transaction with last set closes the run. out_if
//   carries one result per run: first nonzero height, variance, too_few flag.
//   while loading, in_if.ready is high and a sample is taken every cycle.
//   after the last transaction ready drops while the result is computed.
//   the mean and the final scale each go through the shared divider at one
//   quotient bit per cycle, and the second pass reads one store entry per
//   cycle through a three-stage read/square/accumulate pipeline on the
//   shared multiplier. a run with fewer than two samples skips the computation
//   and is reported as too_few with zero variance.
//   samples beyond the store depth are dropped.
//   the result sits in an output register; a stalled receiver holds it there
//   while the next run loads, and only the next result waits for it to drain.
//   reset (synchronous, active low) clears the sample count, sum, height latch
//   and output valid; the sample store is not cleared and needs no sweep.
module sample_variance_engine_core import sve_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  sve_in_if.sink    in_if,
  sve_out_if.source out_if
);

  sve_state_t state_r, state_nxt;

  // run state
  logic        [CNT_W-1:0]       count_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic signed [HEIGHT_BITS-1:0] height_r;
  logic                          latched_r;

  logic                          in_acc;
  logic                          room;
  logic                          take_h;
  logic        [CNT_W-1:0]       count_nxt;
  logic signed [SUM_W-1:0]       sum_nxt;
  logic signed [HEIGHT_BITS-1:0] height_nxt;
  logic                          few_nxt;

  // compute datapath
  logic signed [MEAN_W-1:0]    mean_r, mean_nxt;
  logic        [DVS_W-1:0]     den_r;
  logic        [ACC_W-1:0]     acc_r, acc_nxt;
  logic        [ACC_W-1:0]     lo_r;
  logic        [DIV_NUM_W-1:0] num_r, num_nxt;
  logic        [CNT_W-1:0]     rd_idx_r;
  logic                        rd_v_r;
  logic                        mul_v_r;
  logic                        sq_sat_r, sq_sat_nxt;
  logic        [VAR_BITS-1:0]  res_var_r, res_var_nxt;
  logic                        few_r;

  logic signed [MNUM_W-1:0]    mnum;
  logic                        mneg;
  logic        [MNUM_W-1:0]    mmag;
  logic        [MEAN_W-1:0]    qadj;
  logic signed [SAMPLE_BITS-1:0] rd_sample;
  logic signed [DEV_W-1:0]     dev;
  logic        [DEV_W-1:0]     mag;
  logic        [ACC_W-1:0]     mag_ext;
  logic        [ACC_W-1:0]     sq;
  logic        [ACC_W:0]       acc_sum;
  logic                        issue;
  logic                        pass_done;
  logic                        emit_go;

  // shared unit hookup
  logic                 ram_we;
  logic                 ram_re;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [ACC_W-1:0]     mul_p;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DVS_W-1:0]     div_den;
  div_stat_t            div_stat;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DVS_W-1:0]     div_rem;

  // output register
  logic                          out_valid_r;
  logic signed [HEIGHT_BITS-1:0] out_height_r;
  logic        [VAR_BITS-1:0]    out_var_r;
  logic                          out_few_r;

  sve_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (count_r[ADDR_W-1:0]),
    .wdata   (in_if.accel_sample),
    .re      (ram_re),
    .raddr   (rd_idx_r[ADDR_W-1:0]),
    .rdata_r (rd_sample)
  );

  sve_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  sve_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // loading
  always_comb begin
    in_acc     = in_if.valid && in_if.ready;
    room       = count_r < CNT_W'(MAX_SAMPLES);
    take_h     = in_if.has_height && (in_if.height_cm != '0) && !latched_r;
    count_nxt  = room ? count_r + 1'b1 : count_r;
    sum_nxt    = room ? sum_r + SUM_W'(in_if.accel_sample) : sum_r;
    height_nxt = take_h ? in_if.height_cm : height_r;
    few_nxt    = count_nxt < CNT_W'(2);
  end

  // mean numerator sum*256 + n/2, split into sign and magnitude
  always_comb begin
    mnum     = (MNUM_W'(sum_r) <<< FRAC_BITS) + MNUM_W'(count_r >> 1);
    mneg     = mnum[MNUM_W-1];
    mmag     = mneg ? MNUM_W'(-mnum) : MNUM_W'(mnum);
    // floor division toward minus infinity
    qadj     = div_quo[MEAN_W-1:0] + MEAN_W'(mneg && (div_rem != '0));
    mean_nxt = mneg ? -$signed(qadj) : $signed(qadj);
  end

  // second pass: deviation, square, saturating accumulate
  always_comb begin
    issue      = (state_r == S_PASS) && (rd_idx_r != count_r);
    pass_done  = (state_r == S_PASS) && !issue && !rd_v_r && !mul_v_r;
    dev        = (DEV_W'(rd_sample) <<< FRAC_BITS) - DEV_W'(mean_r);
    mag        = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
    mag_ext    = ACC_W'(mag);
    sq_sat_nxt = |mag_ext[ACC_W-1:MUL_W];
    sq         = sq_sat_r ? '1 : mul_p;
    acc_sum    = {1'b0, acc_r} + {1'b0, sq};
    acc_nxt    = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    // acc*2401 >> 16, from the two half products
    num_nxt    = (mul_p << Q_SHIFT) + (lo_r >> Q_SHIFT);
    res_var_nxt = (|div_quo[DIV_NUM_W-1:VAR_BITS]) ? '1 : div_quo[VAR_BITS-1:0];
    emit_go    = (state_r == S_EMIT) && (!out_valid_r || out_if.ready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc && in_if.last) begin
          state_nxt = few_nxt ? S_EMIT : S_DEN;
        end
      end
      S_DEN:       state_nxt = S_MDIV_GO;
      S_MDIV_GO:   state_nxt = S_MDIV_WAIT;
      S_MDIV_WAIT: if (div_stat.done) state_nxt = S_PASS;
      S_PASS:      if (pass_done) state_nxt = S_SC_LO;
      S_SC_LO:     state_nxt = S_SC_HI;
      S_SC_HI:     state_nxt = S_SC_SUM;
      S_SC_SUM:    state_nxt = S_FDIV_GO;
      S_FDIV_GO:   state_nxt = S_FDIV_WAIT;
      S_FDIV_WAIT: if (div_stat.done) state_nxt = S_EMIT;
      S_EMIT:      if (emit_go) state_nxt = S_LOAD;
      default:     state_nxt = S_LOAD;
    endcase
  end

  // unit controls
  always_comb begin
    in_if.ready = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_num     = DIV_NUM_W'(mmag);
    div_den     = DVS_W'(count_r);
    unique case (state_r)
      S_LOAD: begin
        in_if.ready = 1'b1;
        ram_we      = in_acc && room;
      end
      S_DEN: begin
        mul_a = MUL_W'(count_r - 1'b1);
        mul_b = MUL_W'(SCALE_DEN);
      end
      S_MDIV_GO: begin
        div_start = 1'b1;
      end
      S_PASS: begin
        ram_re = issue;
        mul_a  = mag_ext[MUL_W-1:0];
        mul_b  = mag_ext[MUL_W-1:0];
      end
      S_SC_LO: begin
        mul_a = acc_r[MUL_W-1:0];
        mul_b = MUL_W'(SCALE_NUM);
      end
      S_SC_HI: begin
        mul_a = acc_r[ACC_W-1:MUL_W];
        mul_b = MUL_W'(SCALE_NUM);
      end
      S_FDIV_GO: begin
        div_start = 1'b1;
        div_num   = num_r + DIV_NUM_W'(den_r >> 1);
        div_den   = den_r;
      end
      S_MDIV_WAIT, S_SC_SUM, S_FDIV_WAIT, S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      sum_r       <= '0;
      height_r    <= '0;
      latched_r   <= 1'b0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      mul_v_r <= rd_v_r;
      if (emit_go) begin
        count_r   <= '0;
        sum_r     <= '0;
        height_r  <= '0;
        latched_r <= 1'b0;
      end else if (in_acc) begin
        count_r   <= count_nxt;
        sum_r     <= sum_nxt;
        height_r  <= height_nxt;
        latched_r <= latched_r || take_h;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && in_acc && in_if.last) begin
      few_r     <= few_nxt;
      res_var_r <= '0;
    end
    if (state_r == S_MDIV_GO) begin
      den_r <= mul_p[DVS_W-1:0];
    end
    if (state_r == S_MDIV_WAIT && div_stat.done) begin
      mean_r   <= mean_nxt;
      acc_r    <= '0;
      rd_idx_r <= '0;
    end
    if (issue) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
    if (rd_v_r) begin
      sq_sat_r <= sq_sat_nxt;
    end
    if (mul_v_r) begin
      acc_r <= acc_nxt;
    end
    if (state_r == S_SC_HI) begin
      lo_r <= mul_p;
    end
    if (state_r == S_SC_SUM) begin
      num_r <= num_nxt;
    end
    if (state_r == S_FDIV_WAIT && div_stat.done) begin
      res_var_r <= res_var_nxt;
    end
    if (emit_go) begin
      out_height_r <= height_r;
      out_var_r    <= res_var_r;
      out_few_r    <= few_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.initial_height = out_height_r;
  assign out_if.accel_variance = out_var_r;
  assign out_if.too_few        = out_few_r;

endmodule

@@ hdl/sve_chk.sv @@
// sve_chk: port-level checks for sample_variance_engine_core, bound to the top
// depends on sve_pkg for field widths
module sve_chk import sve_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [HEIGHT_BITS-1:0] out_initial_height,
  input logic        [VAR_BITS-1:0]    out_accel_variance,
  input logic                          out_too_few
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_initial_height) && $stable(out_accel_variance) && $stable(out_too_few))
    else $error("result payload changed while stalled");

  // short runs report zero variance
  a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_few |-> out_accel_variance == '0)
    else $error("too_few result with nonzero variance");

  // closing a run always takes the block out of loading
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still ready after last transaction");

endmodule

bind sample_variance_engine_core sve_chk u_sve_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .in_last            (in_if.last),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_initial_height (out_if.initial_height),
  .out_accel_variance (out_if.accel_variance),
  .out_too_few        (out_if.too_few)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for sample_variance_engine_core, with burst
// stimulus, a stalling result receiver and an in-bench variance predictor
// depends on sve_pkg, sve_in_if / sve_out_if and the core itself
module testbench;
  import sve_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] accel_t;
  typedef logic signed [HEIGHT_BITS-1:0] height_t;

  typedef struct packed {
    height_t             init_height;
    logic [VAR_BITS-1:0] variance;
    logic                too_few;
  } run_result_t;

  typedef struct {
    accel_t      accel;
    logic        has_height;
    height_t     height;
    logic        last;
    logic        known;
    run_result_t res;
  } sample_item_t;

  typedef enum int {RUN_SINGLE, RUN_PAIR, RUN_SHORT, RUN_FILL} run_kind_t;
  typedef enum int {AS_FULL, AS_CLUSTER, AS_EXTREME} accel_style_t;
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_CHOKED} rx_mode_t;

  localparam int RANDOM_ITEMS = 1580;
  localparam int FILL_RUN     = 20;
  localparam int HOLD_RUN     = 4;
  localparam int HOLD_CYCLES  = 3000;
  localparam int TAIL_CYCLES  = 300;
  localparam int SCALE_Q      = 65536;
  localparam run_result_t NO_RES = '0;

  // directed rows: expected result typed in only where it is obvious
  localparam int N_ROWS = 18;
  sample_item_t directed_rows [N_ROWS] = '{
    '{15'sd0,      1'b0, 21'sd0,        1'b1, 1'b1, '{21'sd0, 32'd0, 1'b1}},
    '{-15'sd16384, 1'b1, -21'sd100000,  1'b1, 1'b1, '{-21'sd100000, 32'd0, 1'b1}},
    '{15'sd16383,  1'b1, 21'sd0,        1'b0, 1'b0, NO_RES},
    '{-15'sd16384, 1'b0, 21'sd12345,    1'b0, 1'b0, NO_RES},
    '{15'sd16383,  1'b1, 21'sd1000000,  1'b0, 1'b0, NO_RES},
    '{-15'sd16384, 1'b1, -21'sd1048576, 1'b1, 1'b0, NO_RES},
    '{15'sd100,    1'b1, 21'sd7,        1'b0, 1'b0, NO_RES},
    '{15'sd100,    1'b0, 21'sd0,        1'b1, 1'b1, '{21'sd7, 32'd0, 1'b0}},
    '{-15'sd1,     1'b1, -21'sd1,       1'b0, 1'b0, NO_RES},
    '{15'sd1,      1'b0, 21'sd0,        1'b1, 1'b0, NO_RES},
    '{15'sd0,      1'b1, 21'sd1048575,  1'b0, 1'b0, NO_RES},
    '{15'sd16383,  1'b0, 21'sd0,        1'b0, 1'b0, NO_RES},
    '{-15'sd16384, 1'b0, 21'sd0,        1'b0, 1'b0, NO_RES},
    '{15'sd16383,  1'b0, 21'sd0,        1'b1, 1'b0, NO_RES},
    '{15'sd5,      1'b1, -21'sd1048576, 1'b1, 1'b1, '{-21'sd1048576, 32'd0, 1'b1}},
    '{-15'sd16384, 1'b0, 21'sd0,        1'b0, 1'b0, NO_RES},
    '{-15'sd16384, 1'b0, 21'sd0,        1'b0, 1'b0, NO_RES},
    '{-15'sd16384, 1'b0, 21'sd0,        1'b1, 1'b1, '{21'sd0, 32'd0, 1'b0}}
  };

  logic clk;
  logic rst_n;

  sve_in_if  in_ch ();
  sve_out_if out_ch ();

  sample_variance_engine_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("sample_variance_engine_core verification failed");
    $finish;
  end

  // predictor state for the run being loaded
  accel_t  run_store [MAX_SAMPLES];
  int      run_count   = 0;
  longint  run_sum     = 0;
  height_t run_height  = '0;
  bit      height_held = 1'b0;

  run_result_t pending_variances [$];
  logic        row_known;
  run_result_t row_result;
  run_result_t predicted;
  run_result_t want;
  run_result_t got;

  int items_taken         = 0;
  int runs_closed         = 0;
  int results_seen        = 0;
  int few_seen            = 0;
  int dropped_samples     = 0;
  int mismatches          = 0;
  int backpressure_cycles = 0;

  logic        rx_hold;
  logic        hold_go;
  rx_mode_t    rx_mode    = RX_OPEN;
  int          rx_left    = 0;
  logic [31:0] rx_pattern = 32'hF0F0_3C3C;
  logic        rx_open;

  int burst_left;

  function automatic longint div_floor(input longint num, input longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // two-pass variance over the held samples, scaled by 0.98^2
  function automatic logic [VAR_BITS-1:0] run_variance();
    longint      n;
    longint      mean_q8;
    longint      dev;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] acc;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] total;
    n = run_count;
    mean_q8 = div_floor(run_sum * 256 + n / 2, n);
    acc = '0;
    for (int i = 0; i < run_count; i++) begin
      dev = longint'(run_store[i]) * 256 - mean_q8;
      mag = (dev < 0) ? 64'(-dev) : 64'(dev);
      sq  = (mag >= 64'h1_0000_0000) ? '1 : mag * mag;
      acc = (acc > ~sq) ? '1 : acc + sq;
    end
    den = 64'(SCALE_DEN) * 64'(SCALE_Q) * 64'(n - 1);
    quo = acc / den;
    rem = acc % den;
    if (quo > 64'hFFFF_FFFF) return '1;
    total = quo * SCALE_NUM + (rem * SCALE_NUM + den / 2) / den;
    if (total > 64'hFFFF_FFFF) return '1;
    return total[VAR_BITS-1:0];
  endfunction

  // one sample transaction into the predictor; returns 1 when a run closes
  function automatic bit absorb_sample(input accel_t a, input logic hh, input height_t h,
                                       input logic lst, output run_result_t res);
    res = '0;
    if (run_count < MAX_SAMPLES) begin
      run_store[run_count] = a;
      run_sum += a;
      run_count++;
    end else begin
      dropped_samples++;
    end
    if (hh && h != 0 && !height_held) begin
      run_height  = h;
      height_held = 1'b1;
    end
    if (!lst) return 1'b0;
    res.init_height = run_height;
    if (run_count < 2) begin
      res.variance = '0;
      res.too_few  = 1'b1;
    end else begin
      res.variance = run_variance();
      res.too_few  = 1'b0;
    end
    run_count   = 0;
    run_sum     = 0;
    run_height  = '0;
    height_held = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string why, input run_result_t exp_r,
                                 input run_result_t act_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected height %0d variance %0d too_few %0b",
               why, exp_r.init_height, exp_r.variance, exp_r.too_few);
      $display("  got height %0d variance %0d too_few %0b",
               act_r.init_height, act_r.variance, act_r.too_few);
    end
  endtask

  // sample transactions feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      items_taken++;
      if (absorb_sample(in_ch.accel_sample, in_ch.has_height, in_ch.height_cm,
                        in_ch.last, predicted)) begin
        runs_closed++;
        pending_variances.push_back(row_known ? row_result : predicted);
      end
    end
    if (rst_n && rx_hold && in_ch.valid && !in_ch.ready) backpressure_cycles++;
  end

  // result transactions against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.too_few) few_seen++;
      got.init_height = out_ch.initial_height;
      got.variance    = out_ch.accel_variance;
      got.too_few     = out_ch.too_few;
      if (pending_variances.size() == 0) begin
        report_mismatch("no result expected", NO_RES, got);
      end else begin
        want = pending_variances.pop_front();
        if (got.init_height !== want.init_height || got.variance !== want.variance ||
            got.too_few !== want.too_few)
          report_mismatch("field mismatch", want, got);
      end
    end
  end

  // receiver: picks a new random stall mode each time its mode counter runs out
  always @(posedge clk) begin
    case (rx_mode)
      RX_OPEN:    rx_open = 1'b1;
      RX_RANDOM:  rx_open = $urandom_range(0, 1);
      RX_PATTERN: rx_open = rx_pattern[0];
      default:    rx_open = ($urandom_range(0, 7) == 0);
    endcase
    out_ch.ready <= rx_open && !rx_hold;
    if (rx_left == 0) begin
      rx_mode    <= rx_mode_t'($urandom_range(0, 3));
      rx_left    <= $urandom_range(32, 256);
      rx_pattern <= $urandom;
    end else begin
      rx_left    <= rx_left - 1;
      rx_pattern <= {rx_pattern[0], rx_pattern[31:1]};
    end
  end

  // long receiver hold-off so the core fills up and stalls its input
  initial begin
    rx_hold = 1'b0;
    wait (hold_go === 1'b1);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_item(input sample_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.accel_sample <= it.accel;
    in_ch.has_height   <= it.has_height;
    in_ch.height_cm    <= it.height;
    in_ch.last         <= it.last;
    row_known          <= it.known;
    row_result         <= it.res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin : stimulus
    sample_item_t item;
    run_kind_t    kind;
    accel_style_t style;
    int           run_len;
    int           run_idx;
    int           random_items;
    int           base;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.accel_sample = '0;
    in_ch.has_height   = 1'b0;
    in_ch.height_cm    = '0;
    in_ch.last         = 1'b0;
    row_known          = 1'b0;
    row_result         = NO_RES;
    hold_go            = 1'b0;
    burst_left         = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_ROWS; r++) send_item(directed_rows[r]);

    random_items = 0;
    run_idx      = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (run_idx == FILL_RUN) begin
        kind = RUN_FILL;
      end else begin
        case ($urandom_range(0, 9))
          0:       kind = RUN_SINGLE;
          1:       kind = RUN_PAIR;
          default: kind = RUN_SHORT;
        endcase
      end
      case (kind)
        RUN_SINGLE: run_len = 1;
        RUN_PAIR:   run_len = 2;
        RUN_SHORT:  run_len = $urandom_range(3, 40);
        default:    run_len = MAX_SAMPLES + $urandom_range(1, 24);
      endcase
      style = accel_style_t'($urandom_range(0, 2));
      base  = int'($urandom_range(0, 30000)) - 15000;
      for (int k = 0; k < run_len; k++) begin
        case (style)
          AS_FULL:    item.accel = accel_t'($urandom_range(0, 32767));
          AS_CLUSTER: item.accel = accel_t'(base + int'($urandom_range(0, 1200)) - 600);
          default:    item.accel = $urandom_range(0, 1) ? 15'sd16383 : -15'sd16384;
        endcase
        item.has_height = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0:       item.height = '0;
          1:       item.height = height_t'($urandom);
          default: item.height = height_t'(int'($urandom_range(0, 1100000)) - 100000);
        endcase
        item.last  = (k == run_len - 1);
        item.known = 1'b0;
        item.res   = NO_RES;
        send_item(item);
        if (kind != RUN_FILL) random_items++;
      end
      run_idx++;
      if (run_idx == HOLD_RUN) hold_go <= 1'b1;
    end
    in_ch.valid <= 1'b0;

    while (pending_variances.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d samples in %0d runs, %0d results checked (%0d too_few)",
             items_taken, runs_closed, results_seen, few_seen);
    $display("store overflow dropped %0d samples; input stalled %0d cycles on hold",
             dropped_samples, backpressure_cycles);
    if (mismatches == 0) begin
      $display("sample_variance_engine_core verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("sample_variance_engine_core verification failed");
    end
    $finish;
  end

endmodule
